// ===== rtl/core/pbtc_pkg.sv =====
// Shared types and constants for the power button tap classifier.
package pbtc_pkg;

  // Default width of the tap age counters.
  localparam int unsigned AgeBitsDefault = 10;

  // Widths of the configuration port and of the register fields.
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned HeldW    = 16;
  localparam int unsigned WinW     = 10;

  // Register values after reset.
  localparam logic             TapEnableRst    = 1'b0;
  localparam logic [HeldW-1:0] LongPressRst    = 16'd400;
  localparam logic [WinW-1:0]  TapWindowRst    = 10'd250;
  localparam logic             DoubleToBackRst = 1'b1;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_TAP_ENABLE     = 8'd0,
    CFG_LONG_PRESS_MS  = 8'd1,
    CFG_TAP_WINDOW_MS  = 8'd2,
    CFG_DOUBLE_TO_BACK = 8'd3
  } cfg_idx_e;

  // Current configuration as seen by the classifier.
  typedef struct packed {
    logic             tap_enable;
    logic [HeldW-1:0] long_press_ms;
    logic [WinW-1:0]  tap_window_ms;
    logic             double_to_back;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic confirm_fired;
    logic back_fired;
    logic double_fired;
  } res_t;

endpackage

// ===== rtl/core/pbtc_cfg_regs.sv =====
// Configuration register file of the power button tap classifier.
module pbtc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic [pbtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbtc_pkg::CfgDataW-1:0] cfg_data_i,
  output pbtc_pkg::cfg_t                cfg_o
);

  pbtc_pkg::cfg_t cfg_q;
  pbtc_pkg::cfg_t cfg_d;

  // Decode a write; indexes beyond the list change nothing.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (pbtc_pkg::cfg_idx_e'(cfg_index_i))
        pbtc_pkg::CFG_TAP_ENABLE:     cfg_d.tap_enable     = cfg_data_i[0];
        pbtc_pkg::CFG_LONG_PRESS_MS:  cfg_d.long_press_ms  = cfg_data_i[pbtc_pkg::HeldW-1:0];
        pbtc_pkg::CFG_TAP_WINDOW_MS:  cfg_d.tap_window_ms  = cfg_data_i[pbtc_pkg::WinW-1:0];
        pbtc_pkg::CFG_DOUBLE_TO_BACK: cfg_d.double_to_back = cfg_data_i[0];
        default:                      cfg_d = cfg_q;
      endcase
    end
  end

  // Registers with their reset values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tap_enable     <= pbtc_pkg::TapEnableRst;
      cfg_q.long_press_ms  <= pbtc_pkg::LongPressRst;
      cfg_q.tap_window_ms  <= pbtc_pkg::TapWindowRst;
      cfg_q.double_to_back <= pbtc_pkg::DoubleToBackRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/pbtc_step.sv =====
// Per-tick next-state and result logic of the power button tap classifier.
module pbtc_step #(
  parameter int unsigned AGE_BITS = pbtc_pkg::AgeBitsDefault
) (
  input  pbtc_pkg::cfg_t               cfg_i,
  input  logic                         release_edge_i,
  input  logic [pbtc_pkg::HeldW-1:0]   held_ms_i,
  input  logic                         poll_confirm_i,
  input  logic                         poll_back_i,
  input  logic                         poll_double_i,
  input  logic                         tap_pending_i,
  input  logic [AGE_BITS-1:0]          pending_age_i,
  input  logic                         double_ready_i,
  input  logic [AGE_BITS-1:0]          ready_age_i,
  input  logic                         release_taken_i,
  output logic                         tap_pending_o,
  output logic [AGE_BITS-1:0]          pending_age_o,
  output logic                         double_ready_o,
  output logic [AGE_BITS-1:0]          ready_age_o,
  output logic                         release_taken_o,
  output pbtc_pkg::res_t               res_o
);

  // Compare width covering both the window register and the age counters.
  localparam int unsigned CmpW = (AGE_BITS > pbtc_pkg::WinW) ? AGE_BITS : pbtc_pkg::WinW;
  // Largest usable window: one below the counter's all-ones value.
  localparam logic [AGE_BITS-1:0] WinLim = {{(AGE_BITS-1){1'b1}}, 1'b0};

  logic [CmpW-1:0]     win_ext;
  logic [AGE_BITS-1:0] win;
  logic [AGE_BITS-1:0] sat;
  logic [AGE_BITS-1:0] p_age;
  logic [AGE_BITS-1:0] r_age;

  // Effective window and age saturation point.
  always_comb begin
    win_ext = CmpW'(cfg_i.tap_window_ms);
    if (win_ext > CmpW'(WinLim)) begin
      win = WinLim;
    end else begin
      win = win_ext[AGE_BITS-1:0];
    end
    sat = win + AGE_BITS'(1);
  end

  // Both ages count up each tick and stop at the saturation point.
  assign p_age = (pending_age_i >= sat) ? sat : pending_age_i + AGE_BITS'(1);
  assign r_age = (ready_age_i >= sat) ? sat : ready_age_i + AGE_BITS'(1);

  // Clear all state when tap handling is off; else expiry, release handling and polls, in that order.
  always_comb begin
    tap_pending_o   = tap_pending_i;
    pending_age_o   = p_age;
    double_ready_o  = double_ready_i;
    ready_age_o     = r_age;
    release_taken_o = release_taken_i;
    res_o           = '0;
    if (!cfg_i.tap_enable) begin
      tap_pending_o   = 1'b0;
      pending_age_o   = '0;
      double_ready_o  = 1'b0;
      ready_age_o     = '0;
      release_taken_o = 1'b0;
    end else begin
      // A double tap nobody took within the window expires.
      if (double_ready_o && (r_age > win)) begin
        double_ready_o = 1'b0;
      end
      // A release edge counts once until the edge input drops again.
      if (!release_edge_i) begin
        release_taken_o = 1'b0;
      end else if (!release_taken_i) begin
        release_taken_o = 1'b1;
        if (held_ms_i >= cfg_i.long_press_ms) begin
          tap_pending_o  = 1'b0;
          double_ready_o = 1'b0;
        end else if (tap_pending_i && (p_age <= win)) begin
          tap_pending_o  = 1'b0;
          double_ready_o = 1'b1;
          ready_age_o    = '0;
        end else begin
          tap_pending_o = 1'b1;
          pending_age_o = '0;
        end
      end
      // Confirm poll takes a single tap whose window has run out.
      if (poll_confirm_i && tap_pending_o && !double_ready_o && (pending_age_o > win)) begin
        tap_pending_o       = 1'b0;
        res_o.confirm_fired = 1'b1;
      end
      // Back or double poll takes a ready double tap, per routing.
      if (poll_back_i && double_ready_o && cfg_i.double_to_back) begin
        double_ready_o   = 1'b0;
        res_o.back_fired = 1'b1;
      end
      if (poll_double_i && double_ready_o && !cfg_i.double_to_back) begin
        double_ready_o     = 1'b0;
        res_o.double_fired = 1'b1;
      end
    end
  end

endmodule

// ===== rtl/core/power_button_tap_classifier_top.sv =====
// Top level of the power button tap classifier: state, result register, ports.
//
// Each input item is one millisecond tick of the power button. The block takes
// one item per clock cycle: an item is accepted whenever the result register is
// empty or its result is taken in the same cycle, and its result appears in the
// result register on the next cycle. The tap state (pending single tap, ready
// double tap, their ages and the release-edge latch) is held in flip-flops and
// updated by a single pass of compare logic at each accepted item. Configuration
// writes are taken every cycle (cfg_ready_o is always high) and should be made
// only while the block is idle. Register indexes beyond the last register are
// accepted and ignored.
module power_button_tap_classifier_top #(
  parameter int unsigned AGE_BITS = pbtc_pkg::AgeBitsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [pbtc_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pbtc_pkg::CfgDataW-1:0] cfg_data_i,
  // Input item channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          release_edge_i,
  input  logic [pbtc_pkg::HeldW-1:0]    held_ms_i,
  input  logic                          poll_confirm_i,
  input  logic                          poll_back_i,
  input  logic                          poll_double_i,
  // Result item channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          confirm_fired_o,
  output logic                          back_fired_o,
  output logic                          double_fired_o
);

  pbtc_pkg::cfg_t cfg;
  pbtc_pkg::res_t res_d;
  pbtc_pkg::res_t res_q;

  logic                tap_pending_q, tap_pending_d;
  logic [AGE_BITS-1:0] pending_age_q, pending_age_d;
  logic                double_ready_q, double_ready_d;
  logic [AGE_BITS-1:0] ready_age_q, ready_age_d;
  logic                release_taken_q, release_taken_d;
  logic                out_valid_q;
  logic                in_fire;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  pbtc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Per-tick classification logic.
  pbtc_step #(
    .AGE_BITS (AGE_BITS)
  ) u_step (
    .cfg_i           (cfg),
    .release_edge_i  (release_edge_i),
    .held_ms_i       (held_ms_i),
    .poll_confirm_i  (poll_confirm_i),
    .poll_back_i     (poll_back_i),
    .poll_double_i   (poll_double_i),
    .tap_pending_i   (tap_pending_q),
    .pending_age_i   (pending_age_q),
    .double_ready_i  (double_ready_q),
    .ready_age_i     (ready_age_q),
    .release_taken_i (release_taken_q),
    .tap_pending_o   (tap_pending_d),
    .pending_age_o   (pending_age_d),
    .double_ready_o  (double_ready_d),
    .ready_age_o     (ready_age_d),
    .release_taken_o (release_taken_d),
    .res_o           (res_d)
  );

  // Accept an item when the result register is free or being drained.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Tap state advances once per accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_pending_q   <= 1'b0;
      pending_age_q   <= '0;
      double_ready_q  <= 1'b0;
      ready_age_q     <= '0;
      release_taken_q <= 1'b0;
    end else if (in_fire) begin
      tap_pending_q   <= tap_pending_d;
      pending_age_q   <= pending_age_d;
      double_ready_q  <= double_ready_d;
      ready_age_q     <= ready_age_d;
      release_taken_q <= release_taken_d;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign confirm_fired_o = res_q.confirm_fired;
  assign back_fired_o    = res_q.back_fired;
  assign double_fired_o  = res_q.double_fired;

endmodule

// ===== verif/power_button_tap_classifier_top_tb.sv =====
// Self-checking testbench for the power button tap classifier top level.
`timescale 1ns / 100ps

module power_button_tap_classifier_top_tb;
  import pbtc_pkg::*;

  localparam int unsigned AGE_W       = AgeBitsDefault;
  localparam int unsigned AGE_MAX     = (1 << AGE_W) - 1;
  localparam int          PREDICT     = -1;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          NPHASES     = 9;
  localparam int          PLAN_LEN    = 36;

  // An index past the last register: the block takes it and ignores it.
  localparam logic [CfgIdxW-1:0] CFG_UNUSED_IDX = 8'hFF;

  // One millisecond tick as it enters the block.
  typedef struct packed {
    logic             release_edge;
    logic [HeldW-1:0] held_ms;
    logic             poll_confirm;
    logic             poll_back;
    logic             poll_double;
  } tick_t;

  // One row of the directed plan: a register write or a tick.
  typedef struct packed {
    logic                is_cfg;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
    tick_t               tick;
    logic                typed;
    res_t                want;
  } row_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [CfgDataW-1:0] cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic                release_edge_i = 1'b0;
  logic [HeldW-1:0]    held_ms_i      = '0;
  logic                poll_confirm_i = 1'b0;
  logic                poll_back_i    = 1'b0;
  logic                poll_double_i  = 1'b0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b0;
  logic                confirm_fired_o;
  logic                back_fired_o;
  logic                double_fired_o;

  // Register copies kept by the predictor.
  logic             cfg_en_q   = TapEnableRst;
  logic [HeldW-1:0] cfg_long_q = LongPressRst;
  logic [WinW-1:0]  cfg_win_q  = TapWindowRst;
  logic             cfg_d2b_q  = DoubleToBackRst;

  // Tap state kept by the predictor.
  logic             tap_armed  = 1'b0;
  logic [AGE_W-1:0] arm_age    = '0;
  logic             dbl_ready  = 1'b0;
  logic [AGE_W-1:0] dbl_age    = '0;
  logic             edge_seen  = 1'b0;

  res_t due_results[$];
  res_t head_result;
  row_t plan [PLAN_LEN];
  int   bad_count   = 0;
  int   cycle_count = 0;
  int   rx_hold     = 0;
  bit   idling_on   = 1'b1;

  power_button_tap_classifier_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .release_edge_i (release_edge_i),
    .held_ms_i      (held_ms_i),
    .poll_confirm_i (poll_confirm_i),
    .poll_back_i    (poll_back_i),
    .poll_double_i  (poll_double_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .confirm_fired_o(confirm_fired_o),
    .back_fired_o   (back_fired_o),
    .double_fired_o (double_fired_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Advance the tap state by one tick and return the poll outcome.
  function automatic res_t classify_tick(tick_t t);
    res_t        r;
    int unsigned win;
    int unsigned sat;
    r   = '0;
    win = (cfg_win_q > AGE_MAX - 1) ? AGE_MAX - 1 : cfg_win_q;
    sat = win + 1;
    arm_age = (arm_age >= sat) ? sat[AGE_W-1:0] : arm_age + 1'b1;
    dbl_age = (dbl_age >= sat) ? sat[AGE_W-1:0] : dbl_age + 1'b1;
    if (!cfg_en_q) begin
      tap_armed = 1'b0;
      arm_age   = '0;
      dbl_ready = 1'b0;
      dbl_age   = '0;
      edge_seen = 1'b0;
    end else begin
      // A double tap nobody took within the window expires.
      if (dbl_ready && dbl_age > win) dbl_ready = 1'b0;
      // A release edge held over several ticks counts once.
      if (!t.release_edge) begin
        edge_seen = 1'b0;
      end else if (!edge_seen) begin
        edge_seen = 1'b1;
        if (t.held_ms >= cfg_long_q) begin
          tap_armed = 1'b0;
          dbl_ready = 1'b0;
        end else if (tap_armed && arm_age <= win) begin
          tap_armed = 1'b0;
          dbl_ready = 1'b1;
          dbl_age   = '0;
        end else begin
          tap_armed = 1'b1;
          arm_age   = '0;
        end
      end
      // Polls are served in the order confirm, back, double.
      if (t.poll_confirm && tap_armed && !dbl_ready && arm_age > win) begin
        tap_armed       = 1'b0;
        r.confirm_fired = 1'b1;
      end
      if (t.poll_back && dbl_ready && cfg_d2b_q) begin
        dbl_ready    = 1'b0;
        r.back_fired = 1'b1;
      end
      if (t.poll_double && dbl_ready && !cfg_d2b_q) begin
        dbl_ready      = 1'b0;
        r.double_fired = 1'b1;
      end
    end
    return r;
  endfunction

  function automatic row_t cfg_row(logic [CfgIdxW-1:0] idx, int unsigned data);
    row_t r;
    r        = '0;
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data[CfgDataW-1:0];
    return r;
  endfunction

  // A tick row; want is PREDICT or the outcome as {confirm, back, double}.
  function automatic row_t tick_row(logic e, int unsigned held, logic pc, logic pb,
                                    logic pd, int want);
    row_t r;
    r                   = '0;
    r.tick.release_edge = e;
    r.tick.held_ms      = held[HeldW-1:0];
    r.tick.poll_confirm = pc;
    r.tick.poll_back    = pb;
    r.tick.poll_double  = pd;
    if (want != PREDICT) begin
      r.typed = 1'b1;
      r.want  = want[2:0];
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("%0t: %s: got %0d, expected %0d", $time, what, got, want);
    bad_count++;
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_TAP_ENABLE:     cfg_en_q   = data[0];
      CFG_LONG_PRESS_MS:  cfg_long_q = data[HeldW-1:0];
      CFG_TAP_WINDOW_MS:  cfg_win_q  = data[WinW-1:0];
      CFG_DOUBLE_TO_BACK: cfg_d2b_q  = data[0];
      default: ;
    endcase
  endtask

  // Stop sending and wait until every expected result item has arrived.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (due_results.size() != 0);
  endtask

  task automatic load_regs(logic en, logic [HeldW-1:0] long_ms, logic [WinW-1:0] win,
                           logic d2b);
    drain_results();
    write_reg(CFG_TAP_ENABLE, {15'd0, en});
    write_reg(CFG_LONG_PRESS_MS, long_ms);
    write_reg(CFG_TAP_WINDOW_MS, {6'd0, win});
    write_reg(CFG_DOUBLE_TO_BACK, {15'd0, d2b});
    cfg_valid_i <= 1'b0;
  endtask

  // Offer one tick, wait for it to be taken, then queue its outcome.
  task automatic send_tick(tick_t t, int want);
    int   gap;
    res_t predicted;
    gap = (idling_on && $urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    release_edge_i <= t.release_edge;
    held_ms_i      <= t.held_ms;
    poll_confirm_i <= t.poll_confirm;
    poll_back_i    <= t.poll_back;
    poll_double_i  <= t.poll_double;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = classify_tick(t);
    due_results.push_back(want == PREDICT ? predicted : res_t'(want[2:0]));
  endtask

  // Result side stalls at random in bursts while idling is on.
  always @(posedge clk_i) begin
    if (rx_hold != 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= rx_hold - 1;
    end else if (idling_on && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      rx_hold     <= $urandom_range(0, 4);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Compare each result item with the oldest expectation.
  always @(posedge clk_i) begin
    if (out_valid_o && out_ready_i) begin
      if (due_results.size() == 0) begin
        flag_mismatch("result item with nothing expected",
                      {confirm_fired_o, back_fired_o, double_fired_o}, 0);
      end else begin
        head_result = due_results.pop_front();
        if (confirm_fired_o !== head_result.confirm_fired)
          flag_mismatch("confirm_fired", confirm_fired_o, head_result.confirm_fired);
        if (back_fired_o !== head_result.back_fired)
          flag_mismatch("back_fired", back_fired_o, head_result.back_fired);
        if (double_fired_o !== head_result.double_fired)
          flag_mismatch("double_fired", double_fired_o, head_result.double_fired);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[power_button_tap_classifier_top] ERROR");
      $finish;
    end
  end

  initial begin
    int               ph;
    int               n_items;
    int               pause_at;
    int               gap_left;
    int               edge_left;
    int               ewin;
    int               r;
    logic [HeldW-1:0] long_ms;
    logic [HeldW-1:0] hold_val;
    logic [WinW-1:0]  win;
    logic             en;
    logic             d2b;
    tick_t            t;
    bit               prev_cfg;

    plan = '{
      // Tap handling is off after reset: nothing fires whatever is asked.
      tick_row(1, 0,     1, 1, 1, 0),
      tick_row(0, 65535, 1, 1, 1, 0),
      cfg_row(CFG_TAP_ENABLE, 1),
      cfg_row(CFG_LONG_PRESS_MS, 100),
      cfg_row(CFG_TAP_WINDOW_MS, 2),
      cfg_row(CFG_DOUBLE_TO_BACK, 1),
      cfg_row(CFG_UNUSED_IDX, 16'hFFFF),
      // Single tap with a held edge, confirmed once its window has run out.
      tick_row(1, 0,     1, 0, 0, PREDICT),
      tick_row(1, 0,     1, 0, 0, PREDICT),
      tick_row(0, 0,     1, 0, 0, PREDICT),
      tick_row(0, 0,     1, 0, 0, PREDICT),
      // Double tap just under the long press time, taken by back at once.
      tick_row(1, 99,    0, 0, 0, PREDICT),
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(1, 50,    1, 1, 1, PREDICT),
      // Double tap polled on the unrouted side, then left to expire.
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(1, 0,     0, 0, 0, PREDICT),
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(1, 0,     0, 0, 1, PREDICT),
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(0, 0,     0, 1, 0, PREDICT),
      // Long presses at the threshold and at full scale; the first clears a pending tap.
      tick_row(1, 0,     0, 0, 0, PREDICT),
      tick_row(0, 0,     0, 0, 0, PREDICT),
      tick_row(1, 100,   0, 0, 0, PREDICT),
      tick_row(0, 0,     1, 0, 0, PREDICT),
      tick_row(1, 65535, 0, 0, 0, PREDICT),
      tick_row(0, 0,     1, 1, 1, PREDICT),
      // Zero window: a pending tap is due on the very next tick.
      cfg_row(CFG_DOUBLE_TO_BACK, 0),
      cfg_row(CFG_TAP_WINDOW_MS, 0),
      cfg_row(CFG_LONG_PRESS_MS, 65535),
      tick_row(1, 65534, 0, 0, 0, PREDICT),
      tick_row(0, 0,     1, 0, 0, PREDICT),
      // Zero long press time with a window above the largest usable one.
      cfg_row(CFG_LONG_PRESS_MS, 0),
      cfg_row(CFG_TAP_WINDOW_MS, 1023),
      tick_row(1, 0,     1, 1, 1, 0),
      tick_row(0, 0,     1, 1, 1, PREDICT)
    };

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed plan.
    prev_cfg = 1'b0;
    foreach (plan[k]) begin
      if (plan[k].is_cfg) begin
        if (!prev_cfg) drain_results();
        write_reg(plan[k].idx, plan[k].data);
        prev_cfg = 1'b1;
      end else begin
        if (prev_cfg) cfg_valid_i <= 1'b0;
        prev_cfg = 1'b0;
        send_tick(plan[k].tick, plan[k].typed ? int'(plan[k].want) : PREDICT);
      end
    end

    // Random phases, each with its own register setting.
    for (ph = 0; ph < NPHASES; ph++) begin
      case (ph)
        0: begin win = 1;    long_ms = $urandom_range(1, 200); end
        1: begin win = 1023; long_ms = 16'hFFFF;               end
        2: begin win = 0;    long_ms = 16'h0000;               end
        3: begin win = 250;  long_ms = 400;                    end
        default: begin
          win     = $urandom_range(1, 12);
          long_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                : $urandom_range(1, 300);
        end
      endcase
      en  = (ph != 4);
      d2b = (ph < 4) ? ph[0] : $urandom_range(0, 1);
      load_regs(en, long_ms, win, d2b);

      idling_on = (ph == NPHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      ewin      = (win > AGE_MAX - 1) ? AGE_MAX - 1 : win;
      n_items   = (ewin > 100) ? 360 : 130;
      pause_at  = $urandom_range(10, n_items - 10);
      gap_left  = $urandom_range(0, 3);
      edge_left = 0;
      hold_val  = '0;

      for (int i = 0; i < n_items; i++) begin
        if (i == pause_at) drain_results();
        t.poll_confirm = ($urandom_range(0, 2) == 0);
        t.poll_back    = ($urandom_range(0, 2) == 0);
        t.poll_double  = ($urandom_range(0, 2) == 0);
        if (edge_left > 0) begin
          // The release edge stays high for a few more ticks.
          t.release_edge = 1'b1;
          t.held_ms      = hold_val;
          edge_left--;
        end else if (gap_left == 0) begin
          // A new release, mostly short, sometimes long, sometimes anything.
          r = $urandom_range(0, 9);
          if (r < 6 && long_ms != 0) hold_val = $urandom_range(0, long_ms - 1);
          else if (r < 8) hold_val = $urandom_range(long_ms, 65535);
          else hold_val = $urandom_range(0, 65535);
          t.release_edge = 1'b1;
          t.held_ms      = hold_val;
          edge_left      = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 2) : 0;
          // Quiet time to the next release, placed around the window edge.
          case ($urandom_range(0, 3))
            0: gap_left = $urandom_range(0, 2);
            1: gap_left = (ewin == 0) ? $urandom_range(0, 1)
                                      : ewin - 1 + $urandom_range(0, 2);
            2: gap_left = $urandom_range(0, ewin);
            default: gap_left = $urandom_range(ewin, 2 * ewin + 3);
          endcase
        end else begin
          t.release_edge = 1'b0;
          t.held_ms      = $urandom_range(0, 65535);
          gap_left--;
        end
        // Occasional noise breaks the well-formed press pattern.
        if ($urandom_range(0, 19) == 0) begin
          t.release_edge = $urandom_range(0, 1);
          t.held_ms      = $urandom_range(0, 65535);
        end
        send_tick(t, PREDICT);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (bad_count == 0) begin
      $display("[power_button_tap_classifier_top] OK");
    end else begin
      $display("[power_button_tap_classifier_top] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/core/pbtc_pkg.sv
rtl/core/pbtc_cfg_regs.sv
rtl/core/pbtc_step.sv
rtl/core/power_button_tap_classifier_top.sv
verif/power_button_tap_classifier_top_tb.sv
